>>> rtl/heartbeat_health_monitor_unit_defines.svh
// assertion macros shared by the heartbeat health monitor rtl
// no dependencies; included by hhm_core, the file that carries concurrent assertions
`ifndef HEARTBEAT_HEALTH_MONITOR_UNIT_DEFINES_SVH
`define HEARTBEAT_HEALTH_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HHM_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("hhm: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define HHM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("hhm: next-cycle check failed");

`endif

>>> rtl/hhm_pkg.sv
// shared types and constants of the heartbeat health monitor
// no dependencies; imported by every module of the block
package hhm_pkg;

    localparam int AGE_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 8;

    // command codes
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
    localparam logic [2:0] CMD_SERVICE   = 3'd2;
    localparam logic [2:0] CMD_FORCE     = 3'd3;
    localparam logic [2:0] CMD_ENABLE    = 3'd4;
    localparam logic [2:0] CMD_DISABLE   = 3'd5;

    // link states
    localparam logic [1:0] ST_NOT_READY = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_DEGRADED  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 2;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [1:0] CFG_FAIL_THR    = 2'd1;
    localparam logic [1:0] CFG_RECOV_THR   = 2'd2;

    localparam int TIMEOUT_RESET   = 10;
    localparam int FAIL_THR_RESET  = 3;
    localparam int RECOV_THR_RESET = 3;

    // input item: cmd, report_ok, force_request
    localparam int IN_FIELD_BITS = 6;
    localparam int IN_TDATA_W    = ((IN_FIELD_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [1:0] link_state;
        logic       state_changed;
        logic       accepted;
        logic       status_valid;
    } hhm_flags_t;

    localparam int FLAGS_BITS = 5;

endpackage

>>> rtl/hhm_cfg_regs.sv
// configuration registers of the heartbeat health monitor
// depends on hhm_pkg
module hhm_cfg_regs
    import hhm_pkg::*;
#(
    parameter int AGE_BITS   = AGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int CFG_W      = (AGE_BITS > COUNT_BITS) ? AGE_BITS : COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic [AGE_BITS-1:0]   heartbeat_timeout,
    output logic [COUNT_BITS-1:0] fail_threshold,
    output logic [COUNT_BITS-1:0] recovery_threshold
);

    logic [AGE_BITS-1:0]   timeout_reg;
    logic [COUNT_BITS-1:0] fail_thr_reg;
    logic [COUNT_BITS-1:0] recov_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= AGE_BITS'(TIMEOUT_RESET);
            fail_thr_reg  <= COUNT_BITS'(FAIL_THR_RESET);
            recov_thr_reg <= COUNT_BITS'(RECOV_THR_RESET);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[AGE_BITS-1:0];
                CFG_FAIL_THR:  fail_thr_reg  <= cfg_data[COUNT_BITS-1:0];
                CFG_RECOV_THR: recov_thr_reg <= cfg_data[COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign heartbeat_timeout  = timeout_reg;
    assign fail_threshold     = fail_thr_reg;
    assign recovery_threshold = recov_thr_reg;

endmodule

>>> rtl/hhm_in_stage.sv
// input register of the heartbeat health monitor: holds one item for the core
// depends on hhm_pkg
module hhm_in_stage
    import hhm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  advance,
    output logic                  item_valid,
    output logic [2:0]            cmd,
    output logic                  report_ok,
    output logic [1:0]            force_request
);

    logic                     valid_reg;
    logic                     valid_next;
    logic [IN_FIELD_BITS-1:0] data_reg;

    // a held item leaves when the core advances, so a new one may enter the same cycle
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata[IN_FIELD_BITS-1:0];
        end
    end

    assign item_valid    = valid_reg;
    assign cmd           = data_reg[2:0];
    assign report_ok     = data_reg[3];
    assign force_request = data_reg[5:4];

endmodule

>>> rtl/hhm_core.sv
// link state, heartbeat age and service counters with their update on each accepted item
// depends on hhm_pkg and heartbeat_health_monitor_unit_defines.svh
`include "heartbeat_health_monitor_unit_defines.svh"
module hhm_core
    import hhm_pkg::*;
#(
    parameter int AGE_BITS   = AGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [2:0]            cmd,
    input  logic                  report_ok,
    input  logic [1:0]            force_request,
    input  logic [AGE_BITS-1:0]   heartbeat_timeout,
    input  logic [COUNT_BITS-1:0] fail_threshold,
    input  logic [COUNT_BITS-1:0] recovery_threshold,
    output hhm_flags_t            flags,
    output logic [AGE_BITS-1:0]   age_out,
    output logic [COUNT_BITS-1:0] fail_out,
    output logic [COUNT_BITS-1:0] recovery_out
);

    localparam logic [AGE_BITS-1:0]   AGE_MAX = {AGE_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  enabled_reg,  enabled_next;
    logic [1:0]            state_reg,    state_next;
    logic [1:0]            fvalue_reg,   fvalue_next;
    logic                  factive_reg,  factive_next;
    logic                  seen_reg,     seen_next;
    logic [AGE_BITS-1:0]   age_reg,      age_next;
    logic [COUNT_BITS-1:0] fail_reg,     fail_next;
    logic [COUNT_BITS-1:0] recov_reg,    recov_next;

    logic                  changed;
    logic                  acc;
    logic [1:0]            target;
    logic [AGE_BITS-1:0]   age_inc;
    logic [COUNT_BITS-1:0] fail_inc;
    logic [COUNT_BITS-1:0] recov_inc;

    assign age_inc   = (age_reg == AGE_MAX) ? age_reg : age_reg + AGE_BITS'(1);
    assign fail_inc  = (fail_reg == CNT_MAX) ? fail_reg : fail_reg + COUNT_BITS'(1);
    assign recov_inc = (recov_reg == CNT_MAX) ? recov_reg : recov_reg + COUNT_BITS'(1);

    always_comb
    begin
        enabled_next = enabled_reg;
        state_next   = state_reg;
        fvalue_next  = fvalue_reg;
        factive_next = factive_reg;
        seen_next    = seen_reg;
        age_next     = age_reg;
        fail_next    = fail_reg;
        recov_next   = recov_reg;
        changed      = 1'b0;
        acc          = 1'b0;
        target       = ST_NOT_READY;

        unique case (cmd)
            CMD_TICK:
            begin
                if (enabled_reg)
                begin
                    acc      = 1'b1;
                    age_next = age_inc;
                    // derivation looks at the age after this tick
                    if (factive_reg)
                    begin
                        target = fvalue_reg;
                    end
                    else if (!seen_reg || age_inc >= heartbeat_timeout)
                    begin
                        target = ST_NOT_READY;
                    end
                    else if (fail_reg >= fail_threshold)
                    begin
                        target = ST_DEGRADED;
                    end
                    else
                    begin
                        target = ST_READY;
                    end
                    changed    = (target != state_reg);
                    state_next = target;
                end
            end
            CMD_HEARTBEAT:
            begin
                if (enabled_reg)
                begin
                    acc = 1'b1;
                    if (report_ok)
                    begin
                        seen_next = 1'b1;
                        age_next  = '0;
                    end
                end
            end
            CMD_SERVICE:
            begin
                if (enabled_reg)
                begin
                    acc = 1'b1;
                    if (report_ok)
                    begin
                        fail_next  = '0;
                        recov_next = recov_inc;
                    end
                    else
                    begin
                        recov_next = '0;
                        fail_next  = fail_inc;
                    end
                    if (recov_next >= recovery_threshold)
                    begin
                        fail_next = '0;
                    end
                end
            end
            CMD_FORCE:
            begin
                if (enabled_reg && force_request <= ST_DEGRADED)
                begin
                    acc          = 1'b1;
                    fvalue_next  = force_request;
                    factive_next = 1'b1;
                    changed      = (force_request != state_reg);
                    state_next   = force_request;
                end
            end
            CMD_ENABLE:
            begin
                enabled_next = 1'b1;
                fvalue_next  = ST_NOT_READY;
                state_next   = ST_NOT_READY;
                factive_next = 1'b0;
                seen_next    = 1'b0;
                age_next     = '0;
                fail_next    = '0;
                recov_next   = '0;
                changed      = 1'b1;
                acc          = 1'b1;
            end
            CMD_DISABLE:
            begin
                // forced value survives a disable
                enabled_next = 1'b0;
                state_next   = ST_NOT_READY;
                factive_next = 1'b0;
                seen_next    = 1'b0;
                age_next     = '0;
                fail_next    = '0;
                recov_next   = '0;
                acc          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            state_reg   <= ST_NOT_READY;
            fvalue_reg  <= ST_NOT_READY;
            factive_reg <= 1'b0;
            seen_reg    <= 1'b0;
            age_reg     <= '0;
            fail_reg    <= '0;
            recov_reg   <= '0;
        end
        else if (fire)
        begin
            enabled_reg <= enabled_next;
            state_reg   <= state_next;
            fvalue_reg  <= fvalue_next;
            factive_reg <= factive_next;
            seen_reg    <= seen_next;
            age_reg     <= age_next;
            fail_reg    <= fail_next;
            recov_reg   <= recov_next;
        end
    end

    assign flags.link_state    = state_next;
    assign flags.state_changed = changed;
    assign flags.accepted      = acc;
    assign flags.status_valid  = enabled_next;
    assign age_out             = age_next;
    assign fail_out            = fail_next;
    assign recovery_out        = recov_next;

    `HHM_ASSERT_NOW(a_disabled_cleared, clk, rst_n, !enabled_reg,
        state_reg == ST_NOT_READY && age_reg == '0 && fail_reg == '0 && recov_reg == '0)
    `HHM_ASSERT_NOW(a_counts_exclusive, clk, rst_n, fail_reg != '0, recov_reg == '0)
    `HHM_ASSERT_NOW(a_force_needs_enable, clk, rst_n, factive_reg, enabled_reg)
    `HHM_ASSERT_NEXT(a_enable_resets, clk, rst_n, fire && cmd == CMD_ENABLE,
        enabled_reg && state_reg == ST_NOT_READY && !factive_reg && !seen_reg)

endmodule

>>> rtl/hhm_out_stage.sv
// result register of the heartbeat health monitor, packs one result item
// depends on hhm_pkg
module hhm_out_stage
    import hhm_pkg::*;
#(
    parameter int AGE_BITS   = AGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int OUT_W      = ((FLAGS_BITS + AGE_BITS + 2 * COUNT_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  hhm_flags_t            flags,
    input  logic [AGE_BITS-1:0]   age_out,
    input  logic [COUNT_BITS-1:0] fail_out,
    input  logic [COUNT_BITS-1:0] recovery_out,
    output logic                  advance,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int FIELD_W = FLAGS_BITS + AGE_BITS + 2 * COUNT_BITS;

    logic               valid_reg;
    logic               valid_next;
    logic [OUT_W-1:0]   data_reg;
    logic [FIELD_W-1:0] packed_fields;

    // register frees up when empty or when its item is taken
    assign advance = !valid_reg || m_tready;

    assign packed_fields = {recovery_out, fail_out, age_out, flags.status_valid,
                            flags.accepted, flags.state_changed, flags.link_state};

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            data_reg <= OUT_W'(packed_fields);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> rtl/heartbeat_health_monitor_unit.sv
// heartbeat health monitor top level: input register, update core, result register
// an accepted item waits in the input register; its result is then registered in the result register
// throughput: one item per cycle while results are taken, as the state registers update on every item
// a stalled result holds the core; the input register still takes one more item
// reset (rst_n low, asynchronous): monitor disabled, state not ready, counters zero,
// timeout 10, fail and recovery thresholds 3
module heartbeat_health_monitor_unit
    import hhm_pkg::*;
#(
    parameter int AGE_BITS   = AGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int CFG_W      = (AGE_BITS > COUNT_BITS) ? AGE_BITS : COUNT_BITS,
    parameter int OUT_W      = ((FLAGS_BITS + AGE_BITS + 2 * COUNT_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd[2:0], report_ok, force_request[1:0], zero fill
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // link_state[1:0], state_changed, accepted, status_valid, age_out,
    // fail_out, recovery_out, zero fill
    output logic [OUT_W-1:0]      m_tdata
);

    logic                  advance;
    logic                  item_valid;
    logic                  fire;
    logic [2:0]            cmd;
    logic                  report_ok;
    logic [1:0]            force_request;
    logic [AGE_BITS-1:0]   heartbeat_timeout;
    logic [COUNT_BITS-1:0] fail_threshold;
    logic [COUNT_BITS-1:0] recovery_threshold;
    hhm_flags_t            flags;
    logic [AGE_BITS-1:0]   age_out;
    logic [COUNT_BITS-1:0] fail_out;
    logic [COUNT_BITS-1:0] recovery_out;

    assign fire = item_valid && advance;

    hhm_cfg_regs #(
        .AGE_BITS   (AGE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wen            (cfg_wen),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .heartbeat_timeout  (heartbeat_timeout),
        .fail_threshold     (fail_threshold),
        .recovery_threshold (recovery_threshold)
    );

    hhm_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .advance       (advance),
        .item_valid    (item_valid),
        .cmd           (cmd),
        .report_ok     (report_ok),
        .force_request (force_request)
    );

    hhm_core #(
        .AGE_BITS   (AGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (fire),
        .cmd                (cmd),
        .report_ok          (report_ok),
        .force_request      (force_request),
        .heartbeat_timeout  (heartbeat_timeout),
        .fail_threshold     (fail_threshold),
        .recovery_threshold (recovery_threshold),
        .flags              (flags),
        .age_out            (age_out),
        .fail_out           (fail_out),
        .recovery_out       (recovery_out)
    );

    hhm_out_stage #(
        .AGE_BITS   (AGE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .OUT_W      (OUT_W)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .flags        (flags),
        .age_out      (age_out),
        .fail_out     (fail_out),
        .recovery_out (recovery_out),
        .advance      (advance),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

>>> tb/sv/tb_heartbeat_health_monitor_unit.sv
// self-checking testbench for heartbeat_health_monitor_unit: command stream in, status items out
// keeps its own model of the monitor and checks every returned item field by field
// depends on hhm_pkg and the heartbeat_health_monitor_unit rtl
module tb_heartbeat_health_monitor_unit;
    import hhm_pkg::*;

    localparam int CFG_BITS    = 16;
    localparam int OUT_BITS    = 40;
    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_WAIT  = 6;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;
    localparam logic [7:0]  CNT_MAX = 8'hFF;

    // command codes the block does not define
    localparam logic [2:0] CMD_RSVD_A = 3'd6;
    localparam logic [2:0] CMD_RSVD_B = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic       ok;
        logic [1:0] req;
    } monitor_cmd_t;

    typedef struct packed {
        logic [1:0]  link_state;
        logic        state_changed;
        logic        accepted;
        logic        status_valid;
        logic [15:0] age;
        logic [7:0]  fails;
        logic [7:0]  recoveries;
    } link_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]  cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // cmd[2:0], report_ok, force_request[1:0], zero fill
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // link_state[1:0], state_changed, accepted, status_valid, age_out,
    // fail_out, recovery_out, zero fill
    logic [OUT_BITS-1:0]  m_tdata;

    monitor_cmd_t pending_cmds[$];
    link_report_t link_reports[$];

    // model of the monitor
    logic        mon_on = 1'b0;
    logic [1:0]  link_st = ST_NOT_READY;
    logic [1:0]  forced_st = ST_NOT_READY;
    logic        forced_on = 1'b0;
    logic [15:0] hb_age = '0;
    logic [7:0]  fail_cnt = '0;
    logic [7:0]  recov_cnt = '0;
    logic        hb_seen = 1'b0;
    logic [15:0] timeout_cfg = 16'(TIMEOUT_RESET);
    logic [7:0]  fail_thr_cfg = 8'(FAIL_THR_RESET);
    logic [7:0]  recov_thr_cfg = 8'(RECOV_THR_RESET);

    logic item_taken = 1'b0;
    logic calm = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_wanted = 0;
    int   holds_done = 0;
    int   items_queued = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   stray_results = 0;
    int   settings_used = 0;
    int   cycle_count = 0;

    heartbeat_health_monitor_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_count, results_seen, items_queued);
            $display("heartbeat_health_monitor_unit test failed");
            $finish;
        end
    end

    function automatic void clear_link_status();
        link_st   = ST_NOT_READY;
        forced_on = 1'b0;
        hb_age    = '0;
        fail_cnt  = '0;
        recov_cnt = '0;
        hb_seen   = 1'b0;
    endfunction

    // advances the model by one command and returns the status item it gives
    function automatic link_report_t link_update(input logic [2:0] cmd, input logic ok,
                                                 input logic [1:0] req);
        link_report_t r;
        logic [1:0]   target;
        r = '0;
        case (cmd)
            CMD_TICK:
            if (mon_on)
            begin
                r.accepted = 1'b1;
                if (hb_age != AGE_MAX)
                    hb_age = hb_age + 16'd1;
                if (forced_on)
                    target = forced_st;
                else if (!hb_seen || hb_age >= timeout_cfg)
                    target = ST_NOT_READY;
                else if (fail_cnt >= fail_thr_cfg)
                    target = ST_DEGRADED;
                else
                    target = ST_READY;
                r.state_changed = (link_st != target);
                link_st = target;
            end
            CMD_HEARTBEAT:
            if (mon_on)
            begin
                r.accepted = 1'b1;
                if (ok)
                begin
                    hb_seen = 1'b1;
                    hb_age  = '0;
                end
            end
            CMD_SERVICE:
            if (mon_on)
            begin
                r.accepted = 1'b1;
                if (ok)
                begin
                    fail_cnt = '0;
                    if (recov_cnt != CNT_MAX)
                        recov_cnt = recov_cnt + 8'd1;
                end
                else
                begin
                    recov_cnt = '0;
                    if (fail_cnt != CNT_MAX)
                        fail_cnt = fail_cnt + 8'd1;
                end
                if (recov_cnt >= recov_thr_cfg)
                    fail_cnt = '0;
            end
            CMD_FORCE:
            if (mon_on && req <= ST_DEGRADED)
            begin
                r.accepted      = 1'b1;
                forced_st       = req;
                forced_on       = 1'b1;
                r.state_changed = (link_st != req);
                link_st         = req;
            end
            CMD_ENABLE:
            begin
                mon_on    = 1'b1;
                forced_st = ST_NOT_READY;
                clear_link_status();
                r.state_changed = 1'b1;
                r.accepted      = 1'b1;
            end
            CMD_DISABLE:
            begin
                mon_on = 1'b0;
                clear_link_status();
                r.accepted = 1'b1;
            end
            default: ;
        endcase
        r.link_state   = link_st;
        r.status_valid = mon_on;
        r.age          = hb_age;
        r.fails        = fail_cnt;
        r.recoveries   = recov_cnt;
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in item %0d, %s: expected %0d, got %0d",
                         results_seen, fname, want, got);
        end
    endtask

    // input acceptance feeds the model, output acceptance is checked against it
    always @(posedge clk)
    begin : monitor
        link_report_t got;
        link_report_t want;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.link_state    = m_tdata[1:0];
                got.state_changed = m_tdata[2];
                got.accepted      = m_tdata[3];
                got.status_valid  = m_tdata[4];
                got.age           = m_tdata[20:5];
                got.fails         = m_tdata[28:21];
                got.recoveries    = m_tdata[36:29];
                results_seen = results_seen + 1;
                if (link_reports.size() == 0)
                begin
                    stray_results++;
                    if (mismatches + stray_results <= 10)
                        $display("item %0d arrived with nothing expected", results_seen);
                end
                else
                begin
                    want = link_reports.pop_front();
                    check_field("link_state", want.link_state, got.link_state);
                    check_field("state_changed", want.state_changed, got.state_changed);
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("status_valid", want.status_valid, got.status_valid);
                    check_field("age_out", want.age, got.age);
                    check_field("fail_out", want.fails, got.fails);
                    check_field("recovery_out", want.recoveries, got.recoveries);
                end
            end
            if (s_tvalid && s_tready)
                link_reports.push_back(link_update(s_tdata[2:0], s_tdata[3], s_tdata[5:4]));
        end
    end

    always @(negedge clk)
    begin : driver
        monitor_cmd_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || item_taken)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= $urandom_range(0, 8);
            end
            else if (pending_cmds.size() > 0)
            begin
                nxt = pending_cmds.pop_front();
                s_tdata  <= {2'b00, nxt.req, nxt.ok, nxt.cmd};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (holds_done != hold_wanted)
        begin
            // long hold-off so both registers fill and s_tready drops
            m_tready   <= 1'b0;
            stall_left <= LONG_HOLD - 1;
            holds_done <= holds_done + 1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic queue_item(input logic [2:0] cmd, input logic ok, input logic [1:0] req);
        monitor_cmd_t c;
        c.cmd = cmd;
        c.ok  = ok;
        c.req = req;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic queue_random(input int count, input int hb_pct, input int ok_pct);
        int         pick;
        logic [2:0] cmd;
        logic       ok;
        logic [1:0] req;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            req  = 2'($urandom_range(0, 3));
            ok   = ($urandom_range(0, 99) < ok_pct);
            if (pick < 2)
                cmd = (pick == 0) ? CMD_RSVD_A : CMD_RSVD_B;
            else if (pick == 2)
                cmd = CMD_DISABLE;
            else if (pick < 5)
                cmd = CMD_ENABLE;
            else if (pick == 5)
                cmd = CMD_FORCE;
            else if (pick < 6 + hb_pct)
            begin
                cmd = CMD_HEARTBEAT;
                ok  = ($urandom_range(0, 99) < 85);
            end
            else if (pick < 31 + hb_pct)
                cmd = CMD_SERVICE;
            else
                cmd = CMD_TICK;
            queue_item(cmd, ok, req);
        end
    endtask

    task automatic queue_repeat(input int count, input logic [2:0] cmd, input logic ok);
        for (int n = 0; n < count; n++)
            queue_item(cmd, ok, 2'($urandom_range(0, 3)));
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_TIMEOUT:   timeout_cfg = value;
            CFG_FAIL_THR:  fail_thr_cfg = value[7:0];
            CFG_RECOV_THR: recov_thr_cfg = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic program_registers(input logic [15:0] timeout, input logic [7:0] fail_thr,
                                     input logic [7:0] recov_thr);
        write_register(CFG_TIMEOUT, timeout);
        write_register(CFG_FAIL_THR, {8'h00, fail_thr});
        write_register(CFG_RECOV_THR, {8'h00, recov_thr});
        settings_used++;
        @(posedge clk);
    endtask

    // every item gives one result, so a count match means the block is idle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen != items_queued);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          timeouts[6];
        int          fail_thrs[6];
        int          recov_thrs[6];
        int          hb_pcts[6];
        int          ok_pcts[6];
        timeouts   = '{10, 0, 65535, 5, 2, 0};
        fail_thrs  = '{3, 0, 255, 1, 4, 0};
        recov_thrs = '{3, 0, 255, 2, 0, 0};
        hb_pcts    = '{20, 15, 25, 15, 30, 20};
        ok_pcts    = '{60, 50, 50, 40, 50, 55};
        timeouts[5]   = $urandom_range(1, 20);
        fail_thrs[5]  = $urandom_range(0, 6);
        recov_thrs[5] = $urandom_range(0, 6);

        wait (rst_n === 1'b1);
        @(posedge clk);

        // disabled monitor rejects everything but enable and disable; then directed commands once enabled
        queue_item(CMD_TICK, 1'b0, 2'd0);
        queue_item(CMD_HEARTBEAT, 1'b1, 2'd0);
        queue_item(CMD_SERVICE, 1'b0, 2'd0);
        queue_item(CMD_FORCE, 1'b0, 2'd1);
        queue_item(CMD_DISABLE, 1'b0, 2'd0);
        queue_item(CMD_RSVD_A, 1'b1, 2'd3);
        queue_item(CMD_RSVD_B, 1'b1, 2'd3);
        queue_item(CMD_ENABLE, 1'b0, 2'd0);
        queue_item(CMD_TICK, 1'b0, 2'd0);
        queue_item(CMD_HEARTBEAT, 1'b0, 2'd0);
        queue_item(CMD_HEARTBEAT, 1'b1, 2'd0);
        queue_item(CMD_TICK, 1'b0, 2'd0);
        queue_repeat(3, CMD_SERVICE, 1'b0);
        queue_item(CMD_TICK, 1'b0, 2'd0);
        queue_repeat(3, CMD_SERVICE, 1'b1);
        queue_item(CMD_TICK, 1'b0, 2'd0);
        queue_item(CMD_FORCE, 1'b0, 2'd3);
        queue_item(CMD_FORCE, 1'b1, 2'd2);
        queue_item(CMD_TICK, 1'b0, 2'd0);
        queue_item(CMD_FORCE, 1'b0, 2'd0);
        queue_item(CMD_ENABLE, 1'b1, 2'd3);
        queue_item(CMD_DISABLE, 1'b1, 2'd3);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            program_registers(16'(timeouts[ph]), 8'(fail_thrs[ph]), 8'(recov_thrs[ph]));
            queue_item(CMD_ENABLE, 1'b0, 2'd0);
            if (ph == 2)
            begin
                // drive both counters into saturation at the top thresholds
                queue_item(CMD_HEARTBEAT, 1'b1, 2'd0);
                queue_repeat(260, CMD_SERVICE, 1'b0);
                queue_item(CMD_TICK, 1'b0, 2'd0);
                queue_repeat(260, CMD_SERVICE, 1'b1);
                queue_item(CMD_TICK, 1'b0, 2'd0);
            end
            queue_random(110, hb_pcts[ph], ok_pcts[ph]);
            if (ph == 1)
                hold_wanted++;
            wait_drained();
        end

        // final stretch without idling: a long run of ticks under a wide timeout
        calm = 1'b1;
        program_registers(16'hFFFF, 8'd2, 8'd2);
        queue_item(CMD_ENABLE, 1'b0, 2'd0);
        queue_item(CMD_HEARTBEAT, 1'b1, 2'd0);
        queue_repeat(100, CMD_TICK, 1'b0);
        queue_random(30, 20, 50);
        wait_drained();

        $display("checked %0d status items from %0d commands over %0d register settings",
                 results_seen, items_queued, settings_used);
        $display("covered rejections, reserved codes, forced states and counter saturation");
        if (mismatches == 0 && stray_results == 0 && link_reports.size() == 0)
            $display("heartbeat_health_monitor_unit test passed");
        else
        begin
            $display("%0d field mismatches, %0d unexpected items, %0d expected items missing",
                     mismatches, stray_results, link_reports.size());
            $display("heartbeat_health_monitor_unit test failed");
        end
        $finish;
    end

endmodule

>>> heartbeat_health_monitor_unit.f
+incdir+rtl
rtl/hhm_pkg.sv
rtl/hhm_cfg_regs.sv
rtl/hhm_in_stage.sv
rtl/hhm_core.sv
rtl/hhm_out_stage.sv
rtl/heartbeat_health_monitor_unit.sv
tb/sv/tb_heartbeat_health_monitor_unit.sv
